// File: hdl/jtag_tap_controller_top_assert.svh
// ----------------------------------------------------------------------------
// TAP controller assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef JTAG_TAP_CONTROLLER_TOP_ASSERT_SVH
`define JTAG_TAP_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JTAP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JTAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/jtap_pkg.sv
// ----------------------------------------------------------------------------
// TAP controller package
// Types, codes and helper functions shared by the TAP controller design.
// ----------------------------------------------------------------------------
`default_nettype none

package jtap_pkg;

	localparam int IR_MAX_DEF   = 32;
	localparam int DR_MAX_DEF   = 64;
	localparam int LEN_W        = 7;   // holds lengths up to 64
	localparam int REG_W        = 64;  // widest shift register handled
	localparam int CFG_W        = 6;
	localparam int CODE_W       = 4;
	localparam logic [CFG_W-1:0] IR_LEN_RESET = 6'd5;

	// Controller states, one-hot.
	typedef enum logic [15:0] {
		TAP_TLR        = 16'h0001,
		TAP_RTI        = 16'h0002,
		TAP_SELECT_DR  = 16'h0004,
		TAP_CAPTURE_DR = 16'h0008,
		TAP_SHIFT_DR   = 16'h0010,
		TAP_EXIT1_DR   = 16'h0020,
		TAP_PAUSE_DR   = 16'h0040,
		TAP_EXIT2_DR   = 16'h0080,
		TAP_UPDATE_DR  = 16'h0100,
		TAP_SELECT_IR  = 16'h0200,
		TAP_CAPTURE_IR = 16'h0400,
		TAP_SHIFT_IR   = 16'h0800,
		TAP_EXIT1_IR   = 16'h1000,
		TAP_PAUSE_IR   = 16'h2000,
		TAP_EXIT2_IR   = 16'h4000,
		TAP_UPDATE_IR  = 16'h8000
	} tap_state_t;

	// External state numbering seen on the result stream.
	localparam logic [CODE_W-1:0] CODE_TLR        = 4'd0;
	localparam logic [CODE_W-1:0] CODE_RTI        = 4'd1;
	localparam logic [CODE_W-1:0] CODE_SELECT_DR  = 4'd2;
	localparam logic [CODE_W-1:0] CODE_CAPTURE_DR = 4'd3;
	localparam logic [CODE_W-1:0] CODE_SHIFT_DR   = 4'd4;
	localparam logic [CODE_W-1:0] CODE_EXIT1_DR   = 4'd5;
	localparam logic [CODE_W-1:0] CODE_PAUSE_DR   = 4'd6;
	localparam logic [CODE_W-1:0] CODE_EXIT2_DR   = 4'd7;
	localparam logic [CODE_W-1:0] CODE_UPDATE_DR  = 4'd8;
	localparam logic [CODE_W-1:0] CODE_SELECT_IR  = 4'd9;
	localparam logic [CODE_W-1:0] CODE_CAPTURE_IR = 4'd10;
	localparam logic [CODE_W-1:0] CODE_SHIFT_IR   = 4'd11;
	localparam logic [CODE_W-1:0] CODE_EXIT1_IR   = 4'd12;
	localparam logic [CODE_W-1:0] CODE_PAUSE_IR   = 4'd13;
	localparam logic [CODE_W-1:0] CODE_EXIT2_IR   = 4'd14;
	localparam logic [CODE_W-1:0] CODE_UPDATE_IR  = 4'd15;

	// Input transaction, last field in the lowest bits.
	typedef struct packed {
		logic [6:0]       pad;
		logic [LEN_W-1:0] dr_load_len;
		logic [63:0]      dr_load;
		logic [31:0]      ir_load;
		logic             tdi;
		logic             tms;
	} in_item_t;

	// Result transaction, last field in the lowest bits.
	typedef struct packed {
		logic [63:0]       dr_value;
		logic              dr_updated;
		logic [31:0]       ir_value;
		logic              ir_updated;
		logic              logic_reset;
		logic [CODE_W-1:0] tap_state;
		logic              tdo;
	} out_item_t;

	localparam int IN_W  = $bits(in_item_t);
	localparam int OUT_W = $bits(out_item_t);

	function automatic logic [CODE_W-1:0] tap_code(input tap_state_t s);
		logic [CODE_W-1:0] c;
		unique case (s)
			TAP_TLR:        c = CODE_TLR;
			TAP_RTI:        c = CODE_RTI;
			TAP_SELECT_DR:  c = CODE_SELECT_DR;
			TAP_CAPTURE_DR: c = CODE_CAPTURE_DR;
			TAP_SHIFT_DR:   c = CODE_SHIFT_DR;
			TAP_EXIT1_DR:   c = CODE_EXIT1_DR;
			TAP_PAUSE_DR:   c = CODE_PAUSE_DR;
			TAP_EXIT2_DR:   c = CODE_EXIT2_DR;
			TAP_UPDATE_DR:  c = CODE_UPDATE_DR;
			TAP_SELECT_IR:  c = CODE_SELECT_IR;
			TAP_CAPTURE_IR: c = CODE_CAPTURE_IR;
			TAP_SHIFT_IR:   c = CODE_SHIFT_IR;
			TAP_EXIT1_IR:   c = CODE_EXIT1_IR;
			TAP_PAUSE_IR:   c = CODE_PAUSE_IR;
			TAP_EXIT2_IR:   c = CODE_EXIT2_IR;
			TAP_UPDATE_IR:  c = CODE_UPDATE_IR;
			default:        c = CODE_TLR;
		endcase
		return c;
	endfunction

	function automatic tap_state_t tap_next(input tap_state_t s, input logic tms);
		tap_state_t n;
		unique case (s)
			TAP_TLR:        n = tms ? TAP_TLR       : TAP_RTI;
			TAP_RTI:        n = tms ? TAP_SELECT_DR : TAP_RTI;
			TAP_SELECT_DR:  n = tms ? TAP_SELECT_IR : TAP_CAPTURE_DR;
			TAP_CAPTURE_DR: n = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
			TAP_SHIFT_DR:   n = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
			TAP_EXIT1_DR:   n = tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
			TAP_PAUSE_DR:   n = tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
			TAP_EXIT2_DR:   n = tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
			TAP_UPDATE_DR:  n = tms ? TAP_SELECT_DR : TAP_RTI;
			TAP_SELECT_IR:  n = tms ? TAP_TLR       : TAP_CAPTURE_IR;
			TAP_CAPTURE_IR: n = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
			TAP_SHIFT_IR:   n = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
			TAP_EXIT1_IR:   n = tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
			TAP_PAUSE_IR:   n = tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
			TAP_EXIT2_IR:   n = tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
			TAP_UPDATE_IR:  n = tms ? TAP_SELECT_DR : TAP_RTI;
			default:        n = TAP_TLR;
		endcase
		return n;
	endfunction

	// A length of zero acts as one; anything above the maximum saturates.
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
	                                               input logic [LEN_W-1:0] maxv);
		logic [LEN_W-1:0] r;
		if (v == '0)
			r = LEN_W'(1);
		else if (v > maxv)
			r = maxv;
		else
			r = v;
		return r;
	endfunction

	function automatic logic [REG_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [REG_W-1:0] m;
		for (int i = 0; i < REG_W; i++)
			m[i] = (LEN_W'(i) < len);
		return m;
	endfunction

	// Move toward bit 0 within the active length and insert at its top bit.
	function automatic logic [REG_W-1:0] shift_in(input logic [REG_W-1:0] r,
	                                              input logic [LEN_W-1:0] len,
	                                              input logic bit_in);
		logic [REG_W:0]   r_ext;
		logic [REG_W-1:0] res;
		r_ext = {1'b0, r};
		for (int i = 0; i < REG_W; i++) begin
			if (LEN_W'(i) == len - LEN_W'(1))
				res[i] = bit_in;
			else if (LEN_W'(i + 1) < len)
				res[i] = r_ext[i+1];
			else
				res[i] = 1'b0;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: hdl/jtag_tap_controller_top.sv
// ----------------------------------------------------------------------------
// TAP controller
// IEEE 1149.1 sixteen-state test access port controller, one TCK period per
// transaction.
// ----------------------------------------------------------------------------
// Each s_axis transaction stands for one whole TCK period and carries tms,
// tdi, the Capture-IR and Capture-DR load values and the selected data
// register length. The controller acts on its present state (capture,
// shift, update or reset pulse) and then moves on along tms. One m_axis
// result transaction leaves per input transaction, carrying tdo, the new
// state number, the three pulse flags and both register contents.
// The instruction register length is written through cfg_we / cfg_wdata;
// the user must write it only while the block is idle, as the block does not enforce it.
// A transaction sits in the input register, then the state update, shift
// and masking logic fill the result register. Throughput is one
// transaction per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transaction, one
// more waits in the input register and s_axis_tready drops until the result
// is taken. Reset (arst_n low) puts the controller in Run-Test/Idle, clears
// both shift registers and tdo, sets the data length to one and the
// instruction length to five, and empties both pipeline registers.
// ----------------------------------------------------------------------------
`default_nettype none

module jtag_tap_controller_top #(
	parameter int IR_MAX = jtap_pkg::IR_MAX_DEF,
	parameter int DR_MAX = jtap_pkg::DR_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Configuration: instruction register length.
	input  wire logic                        cfg_we,
	input  wire logic [jtap_pkg::CFG_W-1:0]  cfg_wdata,
	// Input stream.
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// tms, tdi, ir_load[31:0], dr_load[63:0], dr_load_len[6:0], zero pad
	input  wire logic [jtap_pkg::IN_W-1:0]   s_axis_tdata,
	// Result stream.
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// tdo, tap_state[3:0], logic_reset, ir_updated, ir_value[31:0],
	// dr_updated, dr_value[63:0]
	output logic [jtap_pkg::OUT_W-1:0]       m_axis_tdata
);

	localparam int LEN_W = jtap_pkg::LEN_W;
	localparam int REG_W = jtap_pkg::REG_W;

	// Pipeline registers.
	jtap_pkg::in_item_t   item_s1;
	logic                 valid_s1;
	jtap_pkg::out_item_t  result_s2;
	logic                 valid_s2;

	// Controller state.
	jtap_pkg::tap_state_t      state_q;
	logic [IR_MAX-1:0]         ir_q;
	logic [DR_MAX-1:0]         dr_q;
	logic [LEN_W-1:0]          dr_len_q;
	logic                      tdo_q;
	logic [jtap_pkg::CFG_W-1:0] ir_len_q;

	// Next-period values.
	jtap_pkg::tap_state_t state_d;
	logic [IR_MAX-1:0]    ir_d;
	logic [DR_MAX-1:0]    dr_d;
	logic [LEN_W-1:0]     dr_len_d;
	logic                 tdo_d;
	logic [LEN_W-1:0]     ir_len_eff;
	logic [REG_W-1:0]     ir_wide;
	logic [REG_W-1:0]     dr_wide;
	logic                 lr_flag;
	logic                 iru_flag;
	logic                 dru_flag;
	jtap_pkg::out_item_t  result_d;

	logic advance;

	// The input stage moves on when the result register is free or is being
	// emptied in this cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_len_q <= jtap_pkg::IR_LEN_RESET;
		end else if (cfg_we) begin
			ir_len_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= jtap_pkg::in_item_t'(s_axis_tdata);
		end
	end

	// One TCK period of work: act on the present state, then advance.
	always_comb begin
		ir_len_eff = jtap_pkg::clamp_len(LEN_W'(ir_len_q), LEN_W'(IR_MAX));
		ir_d       = ir_q;
		dr_d       = dr_q;
		dr_len_d   = dr_len_q;
		tdo_d      = tdo_q;
		lr_flag    = 1'b0;
		iru_flag   = 1'b0;
		dru_flag   = 1'b0;
		ir_wide    = '0;
		dr_wide    = '0;

		unique case (state_q)
			jtap_pkg::TAP_TLR: begin
				lr_flag = 1'b1;
			end
			jtap_pkg::TAP_CAPTURE_DR: begin
				dr_len_d = jtap_pkg::clamp_len(item_s1.dr_load_len, LEN_W'(DR_MAX));
				dr_wide  = REG_W'(item_s1.dr_load) & jtap_pkg::len_mask(dr_len_d);
				dr_d     = DR_MAX'(dr_wide);
				tdo_d    = dr_wide[0];
			end
			jtap_pkg::TAP_SHIFT_DR: begin
				dr_wide = jtap_pkg::shift_in(REG_W'(dr_q), dr_len_q, item_s1.tdi);
				dr_d    = DR_MAX'(dr_wide);
				tdo_d   = dr_wide[0];
			end
			jtap_pkg::TAP_UPDATE_DR: begin
				dru_flag = 1'b1;
			end
			jtap_pkg::TAP_CAPTURE_IR: begin
				ir_wide = REG_W'(item_s1.ir_load) & jtap_pkg::len_mask(ir_len_eff);
				ir_d    = IR_MAX'(ir_wide);
				tdo_d   = ir_wide[0];
			end
			jtap_pkg::TAP_SHIFT_IR: begin
				ir_wide = jtap_pkg::shift_in(REG_W'(ir_q), ir_len_eff, item_s1.tdi);
				ir_d    = IR_MAX'(ir_wide);
				tdo_d   = ir_wide[0];
			end
			jtap_pkg::TAP_UPDATE_IR: begin
				iru_flag = 1'b1;
			end
			default: begin
			end
		endcase

		state_d = jtap_pkg::tap_next(state_q, item_s1.tms);

		// Bits of the instruction register above the active length are
		// hidden, since the length may have been changed since the capture.
		result_d.tdo         = tdo_d;
		result_d.tap_state   = jtap_pkg::tap_code(state_d);
		result_d.logic_reset = lr_flag;
		result_d.ir_updated  = iru_flag;
		result_d.ir_value    = 32'(REG_W'(ir_d) & jtap_pkg::len_mask(ir_len_eff));
		result_d.dr_updated  = dru_flag;
		result_d.dr_value    = 64'(dr_d);
	end

	// Controller state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= jtap_pkg::TAP_RTI;
			ir_q     <= '0;
			dr_q     <= '0;
			dr_len_q <= LEN_W'(1);
			tdo_q    <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= state_d;
				ir_q     <= ir_d;
				dr_q     <= dr_d;
				dr_len_q <= dr_len_d;
				tdo_q    <= tdo_d;
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

`include "jtag_tap_controller_top_assert.svh"

	// A period spent in Test-Logic-Reset can only lead to itself or to Run-Test/Idle.
	`JTAP_ASSERT_SAME(a_reset_exit, valid_s2 && result_s2.logic_reset,
		(result_s2.tap_state == jtap_pkg::CODE_TLR) ||
		(result_s2.tap_state == jtap_pkg::CODE_RTI),
		"logic_reset with impossible next state")

	// After either update state the controller is in Run-Test/Idle or Select-DR.
	`JTAP_ASSERT_SAME(a_update_exit,
		valid_s2 && (result_s2.ir_updated || result_s2.dr_updated),
		(result_s2.tap_state == jtap_pkg::CODE_RTI) ||
		(result_s2.tap_state == jtap_pkg::CODE_SELECT_DR),
		"update flag with impossible next state")

	// At most one of the three pulse flags is set in any result.
	`JTAP_ASSERT_SAME(a_one_flag, valid_s2,
		$countones({result_s2.logic_reset, result_s2.ir_updated, result_s2.dr_updated}) <= 1,
		"more than one pulse flag set")

	// An item that leaves the input register always lands in the result register.
	`JTAP_ASSERT_NEXT(a_advance_lands, advance, valid_s2, "advanced item lost")

	// The stored data length never leaves its legal range.
	`JTAP_ASSERT_SAME(a_dr_len_range, 1'b1,
		(dr_len_q != '0) && (dr_len_q <= LEN_W'(DR_MAX)),
		"data register length out of range")

endmodule

`default_nettype wire

// File: test/jtag_tap_controller_top_test.sv
// ----------------------------------------------------------------------------
// TAP controller testbench
// Drives scan sequences and random TMS noise through the stream interface,
// predicts every result transaction in a scoreboard and compares it field by
// field, stepping the instruction register length through several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtag_tap_controller_top_test;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int PHASES       = 8;
	localparam int SETTLE       = 4;

	// Tracks the controller along the accepted input transactions and keeps
	// the result transactions that are still due from the block.
	class tap_period_scoreboard;
		bit [5:0]  ir_len_reg;
		bit [3:0]  tap;
		bit [63:0] ir_reg;
		bit [63:0] dr_reg;
		int        dr_len;
		bit        tdo_q;
		jtap_pkg::out_item_t results_due[$];
		int        errors;

		function new();
			ir_len_reg = jtap_pkg::IR_LEN_RESET;
			tap        = jtap_pkg::CODE_RTI;
			ir_reg     = '0;
			dr_reg     = '0;
			dr_len     = 1;
			tdo_q      = 1'b0;
			errors     = 0;
		endfunction

		function void set_ir_length(bit [5:0] v);
			ir_len_reg = v;
		endfunction

		function int ir_active_len();
			if (ir_len_reg == 0)
				return 1;
			if (ir_len_reg > jtap_pkg::IR_MAX_DEF)
				return jtap_pkg::IR_MAX_DEF;
			return int'(ir_len_reg);
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		function bit [63:0] low_ones(int n);
			if (n >= 64)
				return '1;
			return (64'd1 << n) - 64'd1;
		endfunction

		// Everything moves one place towards bit 0; the new bit enters at the
		// top of the active length.
		function bit [63:0] shift_towards_lsb(bit [63:0] r, int n, bit din);
			bit [63:0] s;
			s = (r & low_ones(n)) >> 1;
			s[n-1] = din;
			return s;
		endfunction

		function bit [3:0] next_tap(bit [3:0] s, bit tms);
			bit [3:0] n;
			case (s)
				jtap_pkg::CODE_TLR:
					n = tms ? jtap_pkg::CODE_TLR : jtap_pkg::CODE_RTI;
				jtap_pkg::CODE_RTI:
					n = tms ? jtap_pkg::CODE_SELECT_DR : jtap_pkg::CODE_RTI;
				jtap_pkg::CODE_SELECT_DR:
					n = tms ? jtap_pkg::CODE_SELECT_IR : jtap_pkg::CODE_CAPTURE_DR;
				jtap_pkg::CODE_CAPTURE_DR:
					n = tms ? jtap_pkg::CODE_EXIT1_DR : jtap_pkg::CODE_SHIFT_DR;
				jtap_pkg::CODE_SHIFT_DR:
					n = tms ? jtap_pkg::CODE_EXIT1_DR : jtap_pkg::CODE_SHIFT_DR;
				jtap_pkg::CODE_EXIT1_DR:
					n = tms ? jtap_pkg::CODE_UPDATE_DR : jtap_pkg::CODE_PAUSE_DR;
				jtap_pkg::CODE_PAUSE_DR:
					n = tms ? jtap_pkg::CODE_EXIT2_DR : jtap_pkg::CODE_PAUSE_DR;
				jtap_pkg::CODE_EXIT2_DR:
					n = tms ? jtap_pkg::CODE_UPDATE_DR : jtap_pkg::CODE_SHIFT_DR;
				jtap_pkg::CODE_SELECT_IR:
					n = tms ? jtap_pkg::CODE_TLR : jtap_pkg::CODE_CAPTURE_IR;
				jtap_pkg::CODE_CAPTURE_IR:
					n = tms ? jtap_pkg::CODE_EXIT1_IR : jtap_pkg::CODE_SHIFT_IR;
				jtap_pkg::CODE_SHIFT_IR:
					n = tms ? jtap_pkg::CODE_EXIT1_IR : jtap_pkg::CODE_SHIFT_IR;
				jtap_pkg::CODE_EXIT1_IR:
					n = tms ? jtap_pkg::CODE_UPDATE_IR : jtap_pkg::CODE_PAUSE_IR;
				jtap_pkg::CODE_PAUSE_IR:
					n = tms ? jtap_pkg::CODE_EXIT2_IR : jtap_pkg::CODE_PAUSE_IR;
				jtap_pkg::CODE_EXIT2_IR:
					n = tms ? jtap_pkg::CODE_UPDATE_IR : jtap_pkg::CODE_SHIFT_IR;
				default:
					n = tms ? jtap_pkg::CODE_SELECT_DR : jtap_pkg::CODE_RTI;
			endcase
			return n;
		endfunction

		// One TCK period: act on the present state, then follow tms.
		function void note_period(jtap_pkg::in_item_t t);
			jtap_pkg::out_item_t e;
			int        irl;
			bit [3:0]  cur;
			irl = ir_active_len();
			cur = tap;
			e   = '0;
			case (cur)
				jtap_pkg::CODE_TLR: begin
					e.logic_reset = 1'b1;
				end
				jtap_pkg::CODE_CAPTURE_DR: begin
					if (t.dr_load_len == 0)
						dr_len = 1;
					else if (t.dr_load_len > jtap_pkg::DR_MAX_DEF)
						dr_len = jtap_pkg::DR_MAX_DEF;
					else
						dr_len = int'(t.dr_load_len);
					dr_reg = t.dr_load & low_ones(dr_len);
					tdo_q  = dr_reg[0];
				end
				jtap_pkg::CODE_SHIFT_DR: begin
					dr_reg = shift_towards_lsb(dr_reg, dr_len, t.tdi);
					tdo_q  = dr_reg[0];
				end
				jtap_pkg::CODE_UPDATE_DR: begin
					e.dr_updated = 1'b1;
				end
				jtap_pkg::CODE_CAPTURE_IR: begin
					ir_reg = {32'd0, t.ir_load} & low_ones(irl);
					tdo_q  = ir_reg[0];
				end
				jtap_pkg::CODE_SHIFT_IR: begin
					ir_reg = shift_towards_lsb(ir_reg, irl, t.tdi);
					tdo_q  = ir_reg[0];
				end
				jtap_pkg::CODE_UPDATE_IR: begin
					e.ir_updated = 1'b1;
				end
				default: begin
				end
			endcase
			tap         = next_tap(cur, t.tms);
			e.tdo       = tdo_q;
			e.tap_state = tap;
			e.ir_value  = 32'(ir_reg & low_ones(irl));
			e.dr_value  = dr_reg & low_ones(dr_len);
			results_due.push_back(e);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(jtap_pkg::out_item_t got);
			jtap_pkg::out_item_t want;
			if (results_due.size() == 0) begin
				$error("result transaction with no expectation waiting: %0h", got);
				errors++;
				return;
			end
			want = results_due.pop_front();
			compare_field("tdo", want.tdo, got.tdo);
			compare_field("tap_state", want.tap_state, got.tap_state);
			compare_field("logic_reset", want.logic_reset, got.logic_reset);
			compare_field("ir_updated", want.ir_updated, got.ir_updated);
			compare_field("ir_value", want.ir_value, got.ir_value);
			compare_field("dr_updated", want.dr_updated, got.dr_updated);
			compare_field("dr_value", want.dr_value, got.dr_value);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [jtap_pkg::CFG_W-1:0] cfg_wdata = jtap_pkg::IR_LEN_RESET;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	// tms, tdi, ir_load[31:0], dr_load[63:0], dr_load_len[6:0], zero pad
	logic [jtap_pkg::IN_W-1:0]  s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// tdo, tap_state[3:0], logic_reset, ir_updated, ir_value[31:0],
	// dr_updated, dr_value[63:0]
	logic [jtap_pkg::OUT_W-1:0] m_axis_tdata;

	tap_period_scoreboard sb = new();

	int burst_left = 0;
	int items_sent = 0;
	int cycles     = 0;
	int stall_cyc  = 0;

	jtag_tap_controller_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog: the slowest correct run stays far below this limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver side. Every accepted result transaction is checked against the
	// oldest prediction, then tready follows a stall pattern chosen by
	// stall_cyc[9:8]: always ready, random stalls, a periodic mask, and long
	// stalls that fill the pipeline and push back on the sender.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(jtap_pkg::out_item_t'(m_axis_tdata));
		stall_cyc <= stall_cyc + 1;
		case (stall_cyc[9:8])
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_axis_tready <= ((stall_cyc % 7) < 4);
			default: m_axis_tready <= ((stall_cyc % 32) >= 20);
		endcase
	end

	// One TCK period as one input transaction. The sender works in bursts; at
	// the end of a burst it either idles for a short random gap or carries
	// straight on into a long burst without any idling.
	task automatic send_item(input bit tms, input bit tdi, input bit [31:0] cap_ir,
	                         input bit [63:0] cap_dr, input bit [6:0] dr_bits);
		jtap_pkg::in_item_t t;
		int       gap;
		t             = '0;
		t.tms         = tms;
		t.tdi         = tdi;
		t.ir_load     = cap_ir;
		t.dr_load     = cap_dr;
		t.dr_load_len = dr_bits;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) < 3) begin
				burst_left = $urandom_range(40, 120);
			end else begin
				gap = $urandom_range(1, 6);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= t;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_period(t);
		burst_left--;
		items_sent++;
	endtask

	// A period whose capture fields only matter if it happens to be a capture.
	task automatic send_rand(input bit tms);
		send_item(tms, 1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom},
		          7'($urandom_range(0, 127)));
	endtask

	// Shortest way back to Run-Test/Idle from wherever the controller is.
	task automatic goto_idle();
		while (sb.tap != jtap_pkg::CODE_RTI)
			send_rand(!(sb.tap == jtap_pkg::CODE_TLR || sb.tap == jtap_pkg::CODE_UPDATE_DR ||
			            sb.tap == jtap_pkg::CODE_UPDATE_IR));
	endtask

	// A complete scan: capture, a number of shift periods, optionally a
	// pause in the middle of the exit path, then update.
	task automatic run_scan(input bit to_ir, input int shifts, input int pauses,
	                        input bit [31:0] cap_ir, input bit [63:0] cap_dr,
	                        input bit [6:0] dr_bits, input bit upd_tms);
		goto_idle();
		send_rand(1'b1);
		if (to_ir)
			send_rand(1'b1);
		send_rand(1'b0);
		send_item(shifts == 0, 1'($urandom_range(0, 1)), cap_ir, cap_dr, dr_bits);
		for (int i = 0; i < shifts; i++)
			send_rand(i == shifts - 1);
		if (pauses > 0) begin
			send_rand(1'b0);
			for (int i = 0; i < pauses; i++)
				send_rand(i == pauses - 1);
		end
		send_rand(1'b1);
		send_rand(upd_tms);
	endtask

	// Data register lengths lean towards short ones, with the out-of-range
	// values and the full width mixed in now and then.
	function automatic bit [6:0] pick_dr_bits();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 7'd0;
		if (r < 12)
			return 7'($urandom_range(65, 127));
		if (r < 25)
			return 7'($urandom_range(13, 64));
		return 7'($urandom_range(1, 12));
	endfunction

	// Stop sending and let every outstanding result come back, then wait out
	// the SETTLE delay, so that a register write finds the block idle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_ir_length(input bit [5:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		sb.set_ir_length(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		bit [5:0] phase_len [PHASES];
		int       target;
		int       r;
		int       n;
		int       len;
		int       shifts;
		bit       to_ir;
		bit [6:0] bits;

		phase_len = '{6'd5, 6'd63, 6'd1, 6'd32, 6'd0, 6'd33, 6'd0, 6'd0};
		phase_len[6] = 6'($urandom_range(2, 31));
		phase_len[7] = 6'($urandom_range(0, 63));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset length of five. An all-ones capture
		// checks that bits beyond the active length are dropped, shifting
		// past the length wraps tdi back out, and a pause sits mid-scan.
		run_scan(1'b1, 6, 1, '1, '0, 7'd1, 1'b0);
		// Data length of zero acts as one; no shift at all.
		run_scan(1'b0, 0, 0, '0, '1, 7'd0, 1'b0);
		// Data length above the maximum saturates; update goes on to
		// Select-DR, then through Select-IR into Test-Logic-Reset.
		run_scan(1'b0, 2, 0, '0, '1, 7'd127, 1'b1);
		send_rand(1'b1);
		send_rand(1'b1);
		send_rand(1'b1);
		send_rand(1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0)
				write_ir_length(phase_len[ph]);
			target = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < target) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					// Noise: arbitrary tms, which also breaks off scans half way
					// and wanders through Test-Logic-Reset.
					n = $urandom_range(1, 12);
					for (int i = 0; i < n; i++)
						send_rand(1'($urandom_range(0, 1)));
				end else begin
					to_ir = $urandom_range(0, 1);
					bits  = pick_dr_bits();
					if (to_ir)
						len = sb.ir_active_len();
					else if (bits == 0)
						len = 1;
					else if (bits > jtap_pkg::DR_MAX_DEF)
						len = jtap_pkg::DR_MAX_DEF;
					else
						len = int'(bits);
					r = $urandom_range(0, 9);
					if (r < 6)
						shifts = len;
					else if (r < 8)
						shifts = $urandom_range(0, len);
					else
						shifts = len + $urandom_range(1, 4);
					run_scan(to_ir, shifts,
					         ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4),
					         $urandom, {$urandom, $urandom}, bits,
					         1'($urandom_range(0, 1)));
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/jtap_pkg.sv
hdl/jtag_tap_controller_top.sv
test/jtag_tap_controller_top_test.sv
